// ----- rtl/core/ess_pkg.sv -----
// Package of shared types and constants for the elevator scan scheduler.
package ess_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int CYL_W       = 16;
  localparam int CC_W        = CYL_W + 1;
  localparam int TOT_W       = 22;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = CC_W;

  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};
  localparam logic [CYL_W-1:0] CYL_MAX   = {CYL_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYLINDER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP       = 2'd2;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_TURN    = 1'b1;

  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [CYL_W-1:0] position;
    logic             kind;
    logic [CYL_W-1:0] seek_distance;
    logic [TOT_W-1:0] travel_sum;
    logic             queue_overflow;
    logic             end_of_schedule;
  } out_item_t;

  // item as it leaves the front: store = fits in the batch, ovf = batch has dropped items
  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             last;
    logic             store;
    logic             ovf;
  } q_entry_t;

  typedef struct packed {
    logic [CYL_W-1:0] start_head;
    logic [CC_W-1:0]  cylinder_count;
    logic             sweep_up;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MASK,
    ST_COUNT,
    ST_FIRST,
    ST_TURN,
    ST_SECOND
  } ess_state_t;

endpackage

// ----- rtl/core/ess_queue.sv -----
// Small FIFO between the front and the back of the scheduler.
module ess_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ess_pkg::q_entry_t din,
  input  logic            pop,
  output ess_pkg::q_entry_t dout,
  output logic            full,
  output logic            empty
);

  ess_pkg::q_entry_t mem_r [ess_pkg::FIFO_DEPTH];
  logic [ess_pkg::FIFO_AW-1:0] wr_ptr_r;
  logic [ess_pkg::FIFO_AW-1:0] rd_ptr_r;
  logic [ess_pkg::FIFO_AW:0]   cnt_r;
  logic [ess_pkg::FIFO_AW:0]   cnt_nxt;

  assign full  = (cnt_r == (ess_pkg::FIFO_AW+1)'(ess_pkg::FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- rtl/core/ess_front.sv -----
// Front end: accepts request items and marks them as stored or dropped.
module ess_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ess_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output ess_pkg::q_entry_t q_data
);

  logic [ess_pkg::CNT_W-1:0] count_r;
  logic [ess_pkg::CNT_W-1:0] count_nxt;
  logic                      ovf_r;
  logic                      ovf_nxt;
  logic                      fits;

  assign busy   = q_full;
  assign q_push = start && !q_full;
  assign fits   = (count_r < ess_pkg::CNT_W'(ess_pkg::QUEUE_DEPTH));

  always_comb begin
    q_data.cylinder = in_item.cylinder;
    q_data.last     = in_item.last;
    q_data.store    = fits;
    q_data.ovf      = ovf_r || !fits;
    count_nxt       = count_r;
    ovf_nxt         = ovf_r;
    if (q_push) begin
      if (in_item.last) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = fits ? count_r + 1'b1 : count_r;
        ovf_nxt   = ovf_r || !fits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ----- rtl/core/ess_back.sv -----
// Back end: sorted insertion store and SCAN order sequencer with result stage.
module ess_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  output logic               q_pop,
  input  ess_pkg::q_entry_t  q_data,
  input  ess_pkg::cfg_t      cfg,
  output logic               out_strobe,
  output ess_pkg::out_item_t out_item
);

  ess_pkg::ess_state_t state_r, state_nxt;

  logic [ess_pkg::CYL_W-1:0] cells_r   [ess_pkg::QUEUE_DEPTH];
  logic [ess_pkg::CYL_W-1:0] cells_nxt [ess_pkg::QUEUE_DEPTH];
  logic [ess_pkg::CYL_W-1:0] below     [ess_pkg::QUEUE_DEPTH];
  logic [ess_pkg::QUEUE_DEPTH-1:0] gt;
  logic [ess_pkg::QUEUE_DEPTH-1:0] lt_mask;
  logic [ess_pkg::QUEUE_DEPTH-1:0] lt_r;
  logic ins_en;

  logic [ess_pkg::CNT_W-1:0] n_r, n_nxt;
  logic [ess_pkg::CNT_W-1:0] k_r, k_nxt;
  logic [ess_pkg::CNT_W-1:0] lower_r, lower_nxt;
  logic [ess_pkg::CNT_W-1:0] fcnt, scnt, idx_full;
  logic [ess_pkg::CYL_W-1:0] prev_r, prev_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      asc;
  logic [ess_pkg::CYL_W-1:0] sel;
  logic [ess_pkg::CC_W-1:0]  top_full;
  logic [ess_pkg::CYL_W-1:0] top, turn;

  logic                      s1_vld_r, s1_vld_nxt;
  logic [ess_pkg::CYL_W-1:0] s1_pos_r, s1_pos_nxt;
  logic                      s1_kind_r, s1_kind_nxt;
  logic                      s1_eos_r, s1_eos_nxt;

  logic [ess_pkg::CYL_W-1:0] cur_r;
  logic [ess_pkg::TOT_W-1:0] total_r;
  logic [ess_pkg::CYL_W-1:0] seek;
  logic [ess_pkg::TOT_W:0]   sum;
  logic [ess_pkg::TOT_W-1:0] tot_sat;
  logic                      out_strobe_r;
  ess_pkg::out_item_t        out_item_r;

  // sorted insertion: entries above the new value shift up by one cell
  always_comb begin
    below[0] = q_data.cylinder;
    for (int i = 1; i < ess_pkg::QUEUE_DEPTH; i++) begin
      below[i] = cells_r[i-1];
    end
    for (int i = 0; i < ess_pkg::QUEUE_DEPTH; i++) begin
      gt[i]      = (ess_pkg::CNT_W'(i) < n_r) && (cells_r[i] > q_data.cylinder);
      lt_mask[i] = (ess_pkg::CNT_W'(i) < n_r) && (cells_r[i] < cfg.start_head);
    end
    cells_nxt[0] = (gt[0] || n_r == '0) ? q_data.cylinder : cells_r[0];
    for (int i = 1; i < ess_pkg::QUEUE_DEPTH; i++) begin
      if (gt[i-1]) begin
        cells_nxt[i] = below[i];
      end else if (gt[i] || ess_pkg::CNT_W'(i) == n_r) begin
        cells_nxt[i] = q_data.cylinder;
      end else begin
        cells_nxt[i] = cells_r[i];
      end
    end
  end

  always_comb begin
    top_full = (cfg.cylinder_count == '0) ? '0 : cfg.cylinder_count - 1'b1;
    top      = (|top_full[ess_pkg::CC_W-1:ess_pkg::CYL_W]) ? ess_pkg::CYL_MAX
                                                           : top_full[ess_pkg::CYL_W-1:0];
    turn     = cfg.sweep_up ? top : '0;
    fcnt     = cfg.sweep_up ? n_r - lower_r : lower_r;
    scnt     = n_r - fcnt;
    asc      = (state_r == ess_pkg::ST_FIRST) ? cfg.sweep_up : !cfg.sweep_up;
    idx_full = asc ? lower_r + k_r : lower_r - ess_pkg::CNT_W'(1) - k_r;
    sel      = cells_r[idx_full[ess_pkg::IDX_W-1:0]];
  end

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    lower_nxt   = lower_r;
    prev_nxt    = prev_r;
    ovf_nxt     = ovf_r;
    q_pop       = 1'b0;
    ins_en      = 1'b0;
    s1_vld_nxt  = 1'b0;
    s1_pos_nxt  = s1_pos_r;
    s1_kind_nxt = s1_kind_r;
    s1_eos_nxt  = s1_eos_r;
    case (state_r)
      ess_pkg::ST_LOAD: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.store) begin
            ins_en = 1'b1;
            n_nxt  = n_r + 1'b1;
          end
          if (q_data.last) begin
            ovf_nxt   = q_data.ovf;
            state_nxt = ess_pkg::ST_MASK;
          end
        end
      end
      ess_pkg::ST_MASK: begin
        state_nxt = ess_pkg::ST_COUNT;
      end
      ess_pkg::ST_COUNT: begin
        lower_nxt = ess_pkg::CNT_W'($countones(lt_r));
        prev_nxt  = cfg.start_head;
        k_nxt     = '0;
        state_nxt = ess_pkg::ST_FIRST;
      end
      ess_pkg::ST_FIRST: begin
        if (k_r < fcnt) begin
          s1_vld_nxt  = 1'b1;
          s1_pos_nxt  = sel;
          s1_kind_nxt = ess_pkg::KIND_REQUEST;
          s1_eos_nxt  = (k_r == fcnt - 1'b1) && (scnt == '0) && (sel == turn);
          prev_nxt    = sel;
          k_nxt       = k_r + 1'b1;
        end else begin
          k_nxt     = '0;
          state_nxt = ess_pkg::ST_TURN;
        end
      end
      ess_pkg::ST_TURN: begin
        if (prev_r != turn) begin
          s1_vld_nxt  = 1'b1;
          s1_pos_nxt  = turn;
          s1_kind_nxt = ess_pkg::KIND_TURN;
          s1_eos_nxt  = (scnt == '0);
          prev_nxt    = turn;
        end
        state_nxt = ess_pkg::ST_SECOND;
      end
      ess_pkg::ST_SECOND: begin
        if (k_r < scnt) begin
          s1_vld_nxt  = 1'b1;
          s1_pos_nxt  = sel;
          s1_kind_nxt = ess_pkg::KIND_REQUEST;
          s1_eos_nxt  = (k_r == scnt - 1'b1);
          prev_nxt    = sel;
          k_nxt       = k_r + 1'b1;
        end else begin
          n_nxt     = '0;
          state_nxt = ess_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = ess_pkg::ST_LOAD;
      end
    endcase
  end

  // result stage: seek distance and saturating running total
  always_comb begin
    seek    = (s1_pos_r >= cur_r) ? s1_pos_r - cur_r : cur_r - s1_pos_r;
    sum     = {1'b0, total_r} + (ess_pkg::TOT_W+1)'(seek);
    tot_sat = sum[ess_pkg::TOT_W] ? ess_pkg::TOTAL_MAX : sum[ess_pkg::TOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ess_pkg::ST_LOAD;
      n_r          <= '0;
      k_r          <= '0;
      lower_r      <= '0;
      ovf_r        <= 1'b0;
      s1_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      n_r          <= n_nxt;
      k_r          <= k_nxt;
      lower_r      <= lower_nxt;
      ovf_r        <= ovf_nxt;
      s1_vld_r     <= s1_vld_nxt;
      out_strobe_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prev_r    <= prev_nxt;
    s1_pos_r  <= s1_pos_nxt;
    s1_kind_r <= s1_kind_nxt;
    s1_eos_r  <= s1_eos_nxt;
    if (ins_en) begin
      cells_r <= cells_nxt;
    end
    if (state_r == ess_pkg::ST_MASK) begin
      lt_r <= lt_mask;
    end
    if (state_r == ess_pkg::ST_COUNT) begin
      cur_r   <= cfg.start_head;
      total_r <= '0;
    end else if (s1_vld_r) begin
      cur_r   <= s1_pos_r;
      total_r <= tot_sat;
    end
    if (s1_vld_r) begin
      out_item_r.position        <= s1_pos_r;
      out_item_r.kind            <= s1_kind_r;
      out_item_r.seek_distance   <= seek;
      out_item_r.travel_sum      <= tot_sat;
      out_item_r.queue_overflow  <= ovf_r;
      out_item_r.end_of_schedule <= s1_eos_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ----- rtl/core/elevator_scan_scheduler.sv -----
// Top level of the SCAN (elevator) disk scheduler.
// Usage:
//   Input: drive in_item with start high; the item is taken at an edge where
//   busy is low. Items are stored in a sorted 32-entry store, one per cycle
//   while the back end is loading, behind a 4-entry queue; items beyond 32
//   in a batch are dropped and flagged. An item with last closes the batch.
//   Output: one result per cycle on out_item, marked by out_strobe for one
//   cycle; there is no backpressure. end_of_schedule marks the final result.
//   After the closing item is popped from the queue, the first result passes
//   through the threshold mask, lower count, select and result registers.
//   Results then follow one per cycle, with a gap after the first sweep and
//   a further gap when no turnaround point is emitted. The sorted insert
//   limits loading to one item per cycle; the scan sequencer limits
//   emission to one result per cycle. The next batch loads into the queue
//   while results still go out.
//   Config: cfg_we writes start_head, cylinder_count or sweep_up by index;
//   write only while idle.
//   Reset (synchronous, rst_n low): empty store and queue, config defaults.
module elevator_scan_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  ess_pkg::in_item_t                 in_item,
  output logic                              out_strobe,
  output ess_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [ess_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ess_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ess_pkg::cfg_t     cfg_r;
  ess_pkg::q_entry_t q_din;
  ess_pkg::q_entry_t q_dout;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_head     <= '0;
      cfg_r.cylinder_count <= ess_pkg::CC_W'(200);
      cfg_r.sweep_up       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ess_pkg::CFG_START_HEAD: begin
          cfg_r.start_head <= cfg_data[ess_pkg::CYL_W-1:0];
        end
        ess_pkg::CFG_CYLINDER_COUNT: begin
          cfg_r.cylinder_count <= cfg_data[ess_pkg::CC_W-1:0];
        end
        ess_pkg::CFG_SWEEP_UP: begin
          cfg_r.sweep_up <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  ess_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_din)
  );

  ess_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  ess_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_dout),
    .cfg        (cfg_r),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ----- rtl/core/ess_checker.sv -----
// Port-level checks for the elevator scan scheduler, bound to the top level.
module ess_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_strobe,
  input ess_pkg::out_item_t out_item
);

  a_no_strobe_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.end_of_schedule |=> !out_strobe)
    else $error("result directly after end of schedule");

  a_turn_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_item.kind == ess_pkg::KIND_TURN) |->
      out_item.seek_distance != '0)
    else $error("turnaround item without head movement");

  a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(out_strobe) && !$past(out_item.end_of_schedule) |->
      out_item.travel_sum >= $past(out_item.travel_sum))
    else $error("running total decreased within a batch");

  a_total_covers_seek: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.travel_sum >= ess_pkg::TOT_W'(out_item.seek_distance))
    else $error("running total below seek distance");

endmodule

bind elevator_scan_scheduler ess_checker u_ess_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

// ----- verif/ess_schedule_check.sv -----
// Checker for the elevator scan scheduler: predicts the SCAN service order and compares results.
`timescale 1ns / 1ps
module ess_schedule_check
  import ess_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_item,
  input  logic                  out_strobe,
  input  out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  cfg_t             mode;
  logic [CYL_W-1:0] held_cyl [QUEUE_DEPTH];
  int               held_n;
  logic             dropped;
  out_item_t        service_order_q [$];

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void visit(input logic [CYL_W-1:0] pos, input logic kind,
                                inout logic [CYL_W-1:0] here, inout int unsigned moved);
    out_item_t        r;
    logic [CYL_W-1:0] step_len;
    step_len = (pos >= here) ? pos - here : here - pos;
    moved    = moved + step_len;
    if (moved > 32'(TOTAL_MAX)) moved = 32'(TOTAL_MAX);
    here = pos;
    r.position        = pos;
    r.kind            = kind;
    r.seek_distance   = step_len;
    r.travel_sum      = moved[TOT_W-1:0];
    r.queue_overflow  = dropped;
    r.end_of_schedule = 1'b0;
    service_order_q.push_back(r);
  endfunction

  function automatic void plan_service_order();
    logic [CYL_W-1:0] order [QUEUE_DEPTH];
    logic [CYL_W-1:0] v, here, top;
    logic [CC_W-1:0]  cc_top;
    int               i, j, below, first;
    int unsigned      moved;
    for (i = 0; i < held_n; i++) begin
      v = held_cyl[i];
      j = i;
      while (j > 0 && order[j-1] > v) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = v;
    end
    cc_top = mode.cylinder_count - 1'b1;
    if (mode.cylinder_count == '0) top = '0;
    else top = cc_top[CC_W-1] ? CYL_MAX : cc_top[CYL_W-1:0];
    below = 0;
    while (below < held_n && order[below] < mode.start_head) below++;
    here  = mode.start_head;
    moved = 0;
    first = service_order_q.size();
    if (mode.sweep_up) begin
      for (i = below; i < held_n; i++) visit(order[i], KIND_REQUEST, here, moved);
      if (here != top) visit(top, KIND_TURN, here, moved);
      for (i = below - 1; i >= 0; i--) visit(order[i], KIND_REQUEST, here, moved);
    end else begin
      for (i = below - 1; i >= 0; i--) visit(order[i], KIND_REQUEST, here, moved);
      if (here != '0) visit('0, KIND_TURN, here, moved);
      for (i = below; i < held_n; i++) visit(order[i], KIND_REQUEST, here, moved);
    end
    if (service_order_q.size() > first)
      service_order_q[service_order_q.size()-1].end_of_schedule = 1'b1;
    held_n  = 0;
    dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      mode.start_head     = '0;
      mode.cylinder_count = CC_W'(200);
      mode.sweep_up       = 1'b1;
      held_n              = 0;
      dropped             = 1'b0;
      fail_count          = 0;
      service_order_q.delete();
    end else begin
      if (out_strobe) begin
        if (service_order_q.size() == 0) begin
          $error("unexpected result at position %0d", out_item.position);
          fail_count++;
        end else begin
          want = service_order_q.pop_front();
          check_field("position", 32'(want.position), 32'(out_item.position));
          check_field("kind", 32'(want.kind), 32'(out_item.kind));
          check_field("seek_distance", 32'(want.seek_distance),
                      32'(out_item.seek_distance));
          check_field("travel_sum", 32'(want.travel_sum), 32'(out_item.travel_sum));
          check_field("queue_overflow", 32'(want.queue_overflow),
                      32'(out_item.queue_overflow));
          check_field("end_of_schedule", 32'(want.end_of_schedule),
                      32'(out_item.end_of_schedule));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_HEAD:     mode.start_head     = cfg_data[CYL_W-1:0];
          CFG_CYLINDER_COUNT: mode.cylinder_count = cfg_data;
          CFG_SWEEP_UP:       mode.sweep_up       = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (held_n < QUEUE_DEPTH) begin
          held_cyl[held_n] = in_item.cylinder;
          held_n++;
        end else begin
          dropped = 1'b1;
        end
        if (in_item.last) plan_service_order();
      end
    end
    pending <= service_order_q.size();
  end

endmodule

// ----- verif/elevator_scan_scheduler_test.sv -----
// Testbench top for the elevator scan scheduler: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module elevator_scan_scheduler_test;
  import ess_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int GROUP_ITEMS   = 12;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_strobe;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int               fail_count;
  int               pending;
  int               cycle_count = 0;
  int               idle_pct;
  int               requests_sent;
  logic [CYL_W-1:0] head_now;
  logic [CC_W-1:0]  count_now;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  elevator_scan_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ess_schedule_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [CYL_W-1:0] top_of(input logic [CC_W-1:0] count);
    logic [CC_W-1:0] t;
    t = count - 1'b1;
    if (count == '0) return '0;
    return t[CC_W-1] ? CYL_MAX : t[CYL_W-1:0];
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic set_mode(input logic [CYL_W-1:0] head, input logic [CC_W-1:0] count,
                          input logic up);
    write_reg(CFG_START_HEAD, CFG_DATA_W'(head));
    write_reg(CFG_CYLINDER_COUNT, count);
    write_reg(CFG_SWEEP_UP, CFG_DATA_W'(up));
    @(posedge clk);
    cfg_we    <= 1'b0;
    head_now  = head;
    count_now = count;
  endtask

  task automatic send_request(input logic [CYL_W-1:0] cyl, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= '{cylinder: cyl, last: last};
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
  endtask

  // hold the sender until every scheduled result is out and the block is quiet
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CYL_W-1:0] pick_cylinder();
    logic [CYL_W-1:0] top;
    top = top_of(count_now);
    case ($urandom_range(0, 9))
      0:       return CYL_W'($urandom);
      1:       return head_now;
      2:       return $urandom_range(0, 1) ? CYL_MAX : '0;
      3:       return top;
      default: return CYL_W'($urandom_range(0, top));
    endcase
  endfunction

  task automatic send_batch();
    int len, k;
    case ($urandom_range(0, 9))
      0:       len = $urandom_range(30, 36);
      1:       len = 1;
      default: len = $urandom_range(2, 8);
    endcase
    for (k = 0; k < len; k++) send_request(pick_cylinder(), k == len - 1);
  endtask

  task automatic random_mode();
    logic [CC_W-1:0]  count;
    logic [CYL_W-1:0] head;
    case ($urandom_range(0, 7))
      0:       count = '0;
      1:       count = CC_W'(1);
      2:       count = CC_W'(65536);
      3:       count = CC_W'($urandom);
      default: count = CC_W'($urandom_range(2, 400));
    endcase
    case ($urandom_range(0, 4))
      0:       head = '0;
      1:       head = CYL_MAX;
      2:       head = CYL_W'($urandom);
      default: head = CYL_W'($urandom_range(0, top_of(count)));
    endcase
    set_mode(head, count, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int phase, grp, mark;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_item       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_START_HEAD;
    cfg_data      = '0;
    idle_pct      = 0;
    requests_sent = 0;
    head_now      = '0;
    count_now     = CC_W'(200);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings; one request past the top cylinder
    send_request('0, 1'b0);
    send_request(CYL_MAX, 1'b0);
    send_request(16'd199, 1'b0);
    send_request(16'd100, 1'b1);
    drain();
    // zero cylinder count, sweeping down
    set_mode(CYL_MAX, '0, 1'b0);
    send_request(16'd5, 1'b0);
    send_request(CYL_MAX, 1'b1);
    drain();
    // cylinder count beyond the cylinder position range
    set_mode(16'd100, '1, 1'b1);
    send_request(16'd100, 1'b1);
    drain();
    // head already at the top
    set_mode(CYL_MAX, CC_W'(65536), 1'b1);
    send_request(CYL_MAX, 1'b0);
    send_request(16'd7, 1'b1);
    drain();
    // head already at cylinder 0 sweeping down
    set_mode('0, CC_W'(1), 1'b0);
    send_request('0, 1'b0);
    send_request(16'd3, 1'b1);
    drain();
    // request equal to head counts as upper
    set_mode(16'd50, CC_W'(200), 1'b0);
    send_request(16'd60, 1'b0);
    send_request(16'd20, 1'b0);
    send_request(16'd50, 1'b0);
    send_request(16'd10, 1'b1);

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 6 : (phase == 1) ? 45 : 0;
      for (grp = 0; grp < 4; grp++) begin
        drain();
        random_mode();
        mark = requests_sent;
        while (requests_sent - mark < GROUP_ITEMS) send_batch();
      end
    end
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
